// ===== rtl/longest_prefix_match_table_core_defines.svh =====
// Assertion macros shared by the prefix table RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LONGEST_PREFIX_MATCH_TABLE_CORE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_TABLE_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define LPM_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Same-cycle implication
`define LPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpm_pkg.sv =====
// Types, codes and helper functions of the prefix table.
// No dependencies; used by the core module.
`default_nettype none

package lpm_pkg;

  localparam int unsigned ADDR_W     = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned IDX_OUT_W  = 6;
  localparam int unsigned V4_KEEP_W  = 32;

  localparam logic [LEN_W-1:0] V4_MAX_LEN = 8'd32;
  localparam logic [LEN_W-1:0] V6_MAX_LEN = 8'd128;

  typedef enum logic [1:0] {
    REQ_GET_INSERT = 2'd0,
    REQ_EXACT      = 2'd1,
    REQ_LONGEST    = 2'd2,
    REQ_SET_INFO   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_INVALID  = 2'd1,
    STS_FULL     = 2'd2,
    STS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One stored table entry; address is kept with host bits cleared
  typedef struct packed {
    logic              info;
    logic              family;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Keeps the top len bits of a 128-bit address; len of 128 or more keeps all
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

  // Clears the bits an IPv4 address does not use
  function automatic logic [ADDR_W-1:0] family_mask(input logic family);
    family_mask = family ? {ADDR_W{1'b1}}
                         : {{V4_KEEP_W{1'b1}}, {(ADDR_W-V4_KEEP_W){1'b0}}};
  endfunction

  function automatic logic [LEN_W-1:0] max_len(input logic family);
    max_len = family ? V6_MAX_LEN : V4_MAX_LEN;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lpm_ifs.sv =====
// Request and response channel interfaces of the prefix table.
// Valid/ready handshake; a word moves when both are high at a clock edge.
`default_nettype none

interface lpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        family;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0]  prefix_len;
  logic        info_value;

  modport source (
    output valid, req_type, family, addr_high, addr_low, prefix_len, info_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, family, addr_high, addr_low, prefix_len, info_value,
    output ready
  );
endinterface

interface lpm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] entry_index;
  logic [7:0] matched_len;
  logic       created;

  modport source (
    output valid, status, entry_index, matched_len, created,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, matched_len, created,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output      logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/longest_prefix_match_table_core.sv =====
// An accepted request is scanned against all stored entries (at most ENTRIES), then
// its response word is registered once the response register is free.
// A new request is taken only after the previous response is loaded; the table
// RAM's single read port scans one entry per cycle.
// Reset: clears the entry count and control state; table contents stay uncleared.
// Depends on lpm_pkg, lpm_ifs, lpm_ram and the assertion macro header.
`default_nettype none
`include "longest_prefix_match_table_core_defines.svh"

module longest_prefix_match_table_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpm_req_if.sink    req_i,
  lpm_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned LEN_W = lpm_pkg::LEN_W;
  localparam int unsigned ADDR_W = lpm_pkg::ADDR_W;

  // control state
  lpm_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;

  // latched request
  lpm_pkg::req_e     req_type_q, req_type_d;
  logic              req_fam_q, req_fam_d;
  logic [LEN_W-1:0]  req_len_q, req_len_d;
  logic              req_info_q, req_info_d;
  logic [ADDR_W-1:0] req_addr_q, req_addr_d;

  // scan results
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic              best_vld_q, best_vld_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [LEN_W-1:0]  best_len_q, best_len_d;

  // response register
  logic                           rsp_vld_q, rsp_vld_d;
  lpm_pkg::status_e               rsp_sts_q, rsp_sts_d;
  logic [lpm_pkg::IDX_OUT_W-1:0]  rsp_idx_q, rsp_idx_d;
  logic [LEN_W-1:0]               rsp_len_q, rsp_len_d;
  logic                           rsp_crt_q, rsp_crt_d;

  // handshake and RAM control
  logic              accept;
  logic              rd_en;
  logic              out_load;
  logic              ram_we;
  logic [IDX_W-1:0]  wr_addr;
  lpm_pkg::entry_t   wr_entry;
  lpm_pkg::entry_t   rd_entry;

  // result of the finished scan
  lpm_pkg::status_e  res_sts;
  logic [IDX_W-1:0]  res_idx;
  logic [LEN_W-1:0]  res_len;
  logic              res_crt;
  logic              len_ok;

  // per-entry compare
  logic              exact_match;
  logic              lpm_match;

  // table storage
  lpm_ram #(
    .WIDTH ($bits(lpm_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  // handshake outputs and RAM read control
  always_comb begin
    req_i.ready = (state_q == lpm_pkg::ST_IDLE);
    rd_en       = (state_q == lpm_pkg::ST_SCAN) && (scan_q < cnt_q);
    out_load    = (state_q == lpm_pkg::ST_DONE) && (!rsp_vld_q || rsp_o.ready);
  end

  assign accept = req_i.valid && req_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpm_pkg::ST_IDLE: if (accept) state_d = lpm_pkg::ST_SCAN;
      lpm_pkg::ST_SCAN: if (!rd_en) state_d = lpm_pkg::ST_DONE;
      lpm_pkg::ST_DONE: if (out_load) state_d = lpm_pkg::ST_IDLE;
      default:          state_d = lpm_pkg::ST_IDLE;
    endcase
  end

  // compare of the entry just read against the latched request
  always_comb begin
    exact_match = (rd_entry.family == req_fam_q) && (rd_entry.len == req_len_q) &&
                  (rd_entry.addr == req_addr_q);
    lpm_match   = rd_entry.info && (rd_entry.family == req_fam_q) &&
                  (rd_entry.len <= req_len_q) &&
                  ((req_addr_q & lpm_pkg::prefix_mask(rd_entry.len)) == rd_entry.addr);
  end

  // request latch and scan bookkeeping
  always_comb begin
    req_type_d = req_type_q;
    req_fam_d  = req_fam_q;
    req_len_d  = req_len_q;
    req_info_d = req_info_q;
    req_addr_d = req_addr_q;
    scan_d     = scan_q;
    pend_d     = 1'b0;
    pidx_d     = scan_q[IDX_W-1:0];
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_len_d = best_len_q;

    if (accept) begin
      req_type_d = lpm_pkg::req_e'(req_i.req_type);
      req_fam_d  = req_i.family;
      req_len_d  = req_i.prefix_len;
      req_info_d = req_i.info_value;
      req_addr_d = {req_i.addr_high, req_i.addr_low} &
                   lpm_pkg::family_mask(req_i.family) &
                   lpm_pkg::prefix_mask(req_i.prefix_len);
      scan_d     = '0;
      hit_d      = 1'b0;
      best_vld_d = 1'b0;
    end

    if (rd_en) begin
      scan_d = scan_q + 1'b1;
      pend_d = 1'b1;
    end

    // first exact hit wins; strict compare keeps the earliest on equal length
    if (pend_q) begin
      if (exact_match && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = pidx_q;
      end
      if (lpm_match && (!best_vld_q || (rd_entry.len > best_len_q))) begin
        best_vld_d = 1'b1;
        best_idx_d = pidx_q;
        best_len_d = rd_entry.len;
      end
    end
  end

  // result decision and table update
  always_comb begin
    len_ok   = (req_len_q <= lpm_pkg::max_len(req_fam_q));
    res_sts  = lpm_pkg::STS_NOTFOUND;
    res_idx  = '0;
    res_len  = '0;
    res_crt  = 1'b0;
    ram_we   = 1'b0;
    wr_addr  = hit_idx_q;
    wr_entry = '{info: req_info_q, family: req_fam_q, len: req_len_q, addr: req_addr_q};
    cnt_d    = cnt_q;

    unique case (req_type_q)
      lpm_pkg::REQ_GET_INSERT: begin
        priority if (!len_ok) begin
          res_sts = lpm_pkg::STS_INVALID;
        end else if (hit_q) begin
          res_sts = lpm_pkg::STS_OK;
          res_idx = hit_idx_q;
          res_len = req_len_q;
        end else if (cnt_q == CNT_W'(ENTRIES)) begin
          res_sts = lpm_pkg::STS_FULL;
        end else begin
          res_sts       = lpm_pkg::STS_OK;
          res_idx       = cnt_q[IDX_W-1:0];
          res_len       = req_len_q;
          res_crt       = 1'b1;
          wr_addr       = cnt_q[IDX_W-1:0];
          wr_entry.info = 1'b0;
          ram_we        = out_load;
          if (out_load) cnt_d = cnt_q + 1'b1;
        end
      end
      lpm_pkg::REQ_EXACT, lpm_pkg::REQ_SET_INFO: begin
        if (hit_q) begin
          res_sts = lpm_pkg::STS_OK;
          res_idx = hit_idx_q;
          res_len = req_len_q;
          ram_we  = out_load && (req_type_q == lpm_pkg::REQ_SET_INFO);
        end
      end
      lpm_pkg::REQ_LONGEST: begin
        if (len_ok && best_vld_q) begin
          res_sts = lpm_pkg::STS_OK;
          res_idx = best_idx_q;
          res_len = best_len_q;
        end
      end
      default: res_sts = lpm_pkg::STS_NOTFOUND;
    endcase
  end

  // response register
  always_comb begin
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    rsp_sts_d = rsp_sts_q;
    rsp_idx_d = rsp_idx_q;
    rsp_len_d = rsp_len_q;
    rsp_crt_d = rsp_crt_q;
    if (out_load) begin
      rsp_vld_d = 1'b1;
      rsp_sts_d = res_sts;
      rsp_idx_d = lpm_pkg::IDX_OUT_W'(res_idx);
      rsp_len_d = res_len;
      rsp_crt_d = res_crt;
    end
  end

  always_comb begin
    rsp_o.valid       = rsp_vld_q;
    rsp_o.status      = rsp_sts_q;
    rsp_o.entry_index = rsp_idx_q;
    rsp_o.matched_len = rsp_len_q;
    rsp_o.created     = rsp_crt_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lpm_pkg::ST_IDLE;
      cnt_q      <= '0;
      scan_q     <= '0;
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
      best_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_q     <= scan_d;
      pend_q     <= pend_d;
      hit_q      <= hit_d;
      best_vld_q <= best_vld_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_type_q <= req_type_d;
    req_fam_q  <= req_fam_d;
    req_len_q  <= req_len_d;
    req_info_q <= req_info_d;
    req_addr_q <= req_addr_d;
    pidx_q     <= pidx_d;
    hit_idx_q  <= hit_idx_d;
    best_idx_q <= best_idx_d;
    best_len_q <= best_len_d;
    rsp_sts_q  <= rsp_sts_d;
    rsp_idx_q  <= rsp_idx_d;
    rsp_len_q  <= rsp_len_d;
    rsp_crt_q  <= rsp_crt_d;
  end

  // checks
  `LPM_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(ENTRIES),
                     "entry count beyond table size")
  `LPM_ASSERT_IMPL(a_we_on_load, clk_i, rst_ni, ram_we,
                   out_load && (state_q == lpm_pkg::ST_DONE),
                   "table write outside response load")
  `LPM_ASSERT_NEXT(a_cnt_on_create, clk_i, rst_ni, out_load && res_crt,
                   cnt_q == $past(cnt_q) + 1'b1, "insert did not advance count")
  `LPM_ASSERT_IMPL(a_best_len, clk_i, rst_ni, (state_q == lpm_pkg::ST_DONE) && best_vld_q,
                   best_len_q <= req_len_q, "best match longer than query")

endmodule

`default_nettype wire
